FILE: rtl/core/hwrf_pkg.sv
// package for the hann windowed real fft: constants, states and table functions
`default_nettype none
package hwrf_pkg;

  localparam int FRAME_SIZE_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int IN_W            = 16;
  localparam int BIN_W           = 6;
  localparam int OUT_W           = 23;
  localparam int COEF_W          = 16;

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef enum logic [3:0] {
    ST_FILL,
    ST_WRD,
    ST_WMUL,
    ST_WWR,
    ST_RD,
    ST_MRE,
    ST_MIM,
    ST_ACC,
    ST_OUT
  } hwrf_state_t;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic mac_en;
    logic use_xq;
    logic sel_win;
    logic sel_sin;
    logic wb_en;
    logic acc_re_en;
    logic acc_im_en;
  } hwrf_ctrl_t;

  // first quadrant cosine, even taylor series in horner form
  function automatic longint cos_quad(input longint x);
    longint x2;
    longint t;
    longint p;
    longint Dk;
    x2 = (x * x) >>> 30;
    t  = Q30_ONE;
    for (int k = 6; k >= 1; k--) begin
      Dk = longint'(2 * k) * longint'(2 * k - 1);
      p  = (x2 * t) >>> 30;
      t  = Q30_ONE - p / Dk;
      if (t < 0) t = 0;
    end
    return t;
  endfunction

  function automatic longint cos_phase(input logic [31:0] ph);
    logic [1:0] quad;
    longint     r;
    longint     a;
    longint     x;
    longint     c;
    quad = ph[31:30];
    r    = longint'({34'd0, ph[29:0]});
    a    = quad[0] ? (Q30_ONE - r) : r;
    x    = (a * HALF_PI_Q30) >>> 30;
    c    = cos_quad(x);
    return (quad == 2'd1 || quad == 2'd2) ? -c : c;
  endfunction

  function automatic logic [31:0] phase_of(input longint m, input longint Den);
    longint v;
    v = ((m <<< 32) + Den / 2) / Den;
    return v[31:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] q15_of_q30(input longint v);
    longint r;
    r = (v + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return COEF_W'(r);
  endfunction

  function automatic logic signed [COEF_W-1:0] win_val(input int n, input int Size);
    longint w30;
    longint w;
    w30 = (Q30_ONE - cos_phase(phase_of(longint'(n), longint'(Size - 1)))) >>> 1;
    w   = (w30 + 64'sd16384) >>> 15;
    if (w > 32767) w = 32767;
    return COEF_W'(w);
  endfunction

  function automatic logic signed [COEF_W-1:0] twc_val(input int n, input int Size);
    return q15_of_q30(cos_phase(phase_of(longint'(n), longint'(Size))));
  endfunction

  function automatic logic signed [COEF_W-1:0] tws_val(input int n, input int Size);
    logic [31:0] pt;
    pt = phase_of(longint'(n), longint'(Size)) - 32'h4000_0000;
    return q15_of_q30(-cos_phase(pt));
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/hwrf_smp_if.sv
// sample channel interface
`default_nettype none
interface hwrf_smp_if;
  import hwrf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hwrf_bin_if.sv
// spectrum bin channel interface
`default_nettype none
interface hwrf_bin_if;
  import hwrf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [BIN_W-1:0]        bin_index;
  logic signed [OUT_W-1:0] real_part;
  logic signed [OUT_W-1:0] imag_part;
  logic                    last_bin;
  modport source (output valid, output bin_index, output real_part, output imag_part,
                  output last_bin, input ready);
  modport sink   (input valid, input bin_index, input real_part, input imag_part,
                  input last_bin, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/hann_windowed_real_fft_unit.sv
// top level: frame store, window and dft datapath around one shared multiplier
//
//  channel  | dir | payload                                        | transfer
//  in_ch    | in  | sample (16b signed)                            | valid & ready
//  out_ch   | out | bin_index, real_part, imag_part, last_bin      | valid & ready
//
// samples are taken one per cycle until a frame of FRAME_SIZE is held
// then the block is busy: each sample is read, windowed and written back, then for
// each of FRAME_SIZE/2+1 bins the samples are multiplied by cosine and sine twiddles
// and summed and the bin waits for its request to be taken; the one multiplier is shared
// synchronous reset returns to sample collection with an empty frame
// a stalled output holds the bin and stops the sequencer
`default_nettype none
module hann_windowed_real_fft_unit import hwrf_pkg::*; #(
  parameter int FRAME_SIZE  = FRAME_SIZE_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  hwrf_smp_if.sink   in_ch,
  hwrf_bin_if.source out_ch
);

  localparam int IDX_W = $clog2(FRAME_SIZE);
  localparam int HALF  = FRAME_SIZE / 2;
  localparam int ACC_W = (SAMPLE_BITS + 8 > OUT_W + 1) ? SAMPLE_BITS + 8 : OUT_W + 1;
  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'((64'sd1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] OUT_MIN = ACC_W'(-(64'sd1 <<< (OUT_W - 1)));

  logic signed [COEF_W-1:0] win_tab [FRAME_SIZE];
  logic signed [COEF_W-1:0] cos_tab [FRAME_SIZE];
  logic signed [COEF_W-1:0] sin_tab [FRAME_SIZE];

  for (genvar g = 0; g < FRAME_SIZE; g++) begin : g_tab
    assign win_tab[g] = win_val(g, FRAME_SIZE);
    assign cos_tab[g] = twc_val(g, FRAME_SIZE);
    assign sin_tab[g] = tws_val(g, FRAME_SIZE);
  end

  hwrf_state_t state;
  hwrf_ctrl_t  ctrl;

  logic [IDX_W-1:0] fill;
  logic [IDX_W-1:0] n;
  logic [IDX_W-1:0] m;
  logic [IDX_W-1:0] k;
  logic [IDX_W:0]   m_sum;
  logic             fill_last;
  logic             n_last;
  logic             k_last;

  logic signed [SAMPLE_BITS-1:0] mem [FRAME_SIZE];
  logic signed [SAMPLE_BITS-1:0] mem_q;
  logic signed [SAMPLE_BITS-1:0] xq;
  logic signed [SAMPLE_BITS-1:0] in_x;
  logic signed [SAMPLE_BITS-1:0] mac_a;
  logic signed [COEF_W-1:0]      mac_b;
  logic signed [SAMPLE_BITS:0]   mac_rnd;
  logic signed [ACC_W-1:0]       acc_re;
  logic signed [ACC_W-1:0]       acc_im;
  logic signed [ACC_W-1:0]       im_sum;
  logic in_take;
  logic out_take;

  if (SAMPLE_BITS > IN_W) begin : g_in_wide
    assign in_x = {{(SAMPLE_BITS - IN_W){1'b0}}, in_ch.sample};
  end else begin : g_in_narrow
    assign in_x = in_ch.sample[SAMPLE_BITS-1:0];
  end

  assign fill_last = (fill == IDX_W'(FRAME_SIZE - 1));
  assign n_last    = (n == IDX_W'(FRAME_SIZE - 1));
  assign k_last    = (k == IDX_W'(HALF));
  assign in_take   = in_ch.valid && ctrl.in_ready;
  assign out_take  = ctrl.out_valid && out_ch.ready;
  assign m_sum     = {1'b0, m} + {1'b0, k};

  hwrf_seq #(.FRAME_SIZE(FRAME_SIZE)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .fill_last (fill_last),
    .n_last    (n_last),
    .k_last    (k_last),
    .state     (state),
    .ctrl      (ctrl)
  );

  assign mac_a = ctrl.use_xq ? xq : mem_q;
  assign mac_b = ctrl.sel_win ? win_tab[n] : (ctrl.sel_sin ? sin_tab[m] : cos_tab[m]);

  hwrf_mac #(.A_W(SAMPLE_BITS)) u_mac (
    .clk (clk),
    .en  (ctrl.mac_en),
    .opa (mac_a),
    .opb (mac_b),
    .rnd (mac_rnd)
  );

  // frame store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_take)          mem[fill] <= in_x;
    else if (ctrl.wb_en)  mem[n]    <= mac_rnd[SAMPLE_BITS-1:0];
    mem_q <= mem[n];
  end

  always_ff @(posedge clk) begin
    if (state == ST_MRE) xq <= mem_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (in_take) begin
      fill <= fill_last ? '0 : fill + 1'b1;
    end
  end

  assign im_sum = acc_im + ACC_W'(mac_rnd);

  // index and accumulator sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      m <= '0;
      k <= '0;
    end else begin
      if (in_take && fill_last) begin
        n <= '0;
      end else if (ctrl.wb_en) begin
        n <= n_last ? '0 : n + 1'b1;
        if (n_last) begin
          k <= '0;
          m <= '0;
        end
      end else if (ctrl.acc_im_en) begin
        n <= n_last ? '0 : n + 1'b1;
        m <= (m_sum >= (IDX_W + 1)'(FRAME_SIZE)) ?
             IDX_W'(m_sum - (IDX_W + 1)'(FRAME_SIZE)) : m_sum[IDX_W-1:0];
      end else if (out_take) begin
        n <= '0;
        m <= '0;
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((ctrl.wb_en && n_last) || out_take) begin
      acc_re <= '0;
      acc_im <= '0;
    end else begin
      if (ctrl.acc_re_en) acc_re <= acc_re + ACC_W'(mac_rnd);
      if (ctrl.acc_im_en) acc_im <= im_sum;
    end
  end

  // result register, loaded on the last term of a bin
  always_ff @(posedge clk) begin
    if (ctrl.acc_im_en && n_last) begin
      out_ch.bin_index <= BIN_W'(k);
      out_ch.last_bin  <= k_last;
      if (acc_re > OUT_MAX)      out_ch.real_part <= OUT_W'(OUT_MAX);
      else if (acc_re < OUT_MIN) out_ch.real_part <= OUT_W'(OUT_MIN);
      else                       out_ch.real_part <= OUT_W'(acc_re);
      if (im_sum > OUT_MAX)      out_ch.imag_part <= OUT_W'(OUT_MAX);
      else if (im_sum < OUT_MIN) out_ch.imag_part <= OUT_W'(OUT_MIN);
      else                       out_ch.imag_part <= OUT_W'(im_sum);
    end
  end

  assign in_ch.ready  = ctrl.in_ready;
  assign out_ch.valid = ctrl.out_valid;

endmodule
`default_nettype wire

FILE: rtl/core/hwrf_mac.sv
// shared multiplier with product register and round half up by 2^15
`default_nettype none
module hwrf_mac import hwrf_pkg::*; #(
  parameter int A_W = SAMPLE_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic signed [A_W-1:0]    opa,
  input  wire logic signed [COEF_W-1:0] opb,
  output logic signed [A_W:0]           rnd
);

  localparam int P_W = A_W + COEF_W;

  logic signed [P_W-1:0] prod;
  logic signed [P_W-1:0] biased;

  always_ff @(posedge clk) begin
    if (en) prod <= opa * opb;
  end

  assign biased = prod + P_W'(16384);
  assign rnd    = biased[P_W-1:15];

endmodule
`default_nettype wire

FILE: rtl/core/hwrf_seq.sv
// sequencer for fill, window and per-bin transform passes
`default_nettype none
module hwrf_seq import hwrf_pkg::*; #(
  parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       out_ready,
  input  wire logic       fill_last,
  input  wire logic       n_last,
  input  wire logic       k_last,
  output hwrf_state_t     state,
  output hwrf_ctrl_t      ctrl
);

  hwrf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_FILL;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: if (in_valid && fill_last) state_next = ST_WRD;
      ST_WRD:  state_next = ST_WMUL;
      ST_WMUL: state_next = ST_WWR;
      ST_WWR:  state_next = n_last ? ST_RD : ST_WRD;
      ST_RD:   state_next = ST_MRE;
      ST_MRE:  state_next = ST_MIM;
      ST_MIM:  state_next = ST_ACC;
      ST_ACC:  state_next = n_last ? ST_OUT : ST_RD;
      ST_OUT: begin
        if (out_ready) state_next = k_last ? ST_FILL : ST_RD;
      end
      default: state_next = ST_FILL;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_FILL: ctrl.in_ready = 1'b1;
      ST_WMUL: begin
        ctrl.mac_en  = 1'b1;
        ctrl.sel_win = 1'b1;
      end
      ST_WWR:  ctrl.wb_en = 1'b1;
      ST_MRE:  ctrl.mac_en = 1'b1;
      ST_MIM: begin
        ctrl.mac_en    = 1'b1;
        ctrl.use_xq    = 1'b1;
        ctrl.sel_sin   = 1'b1;
        ctrl.acc_re_en = 1'b1;
      end
      ST_ACC:  ctrl.acc_im_en = 1'b1;
      ST_OUT:  ctrl.out_valid = 1'b1;
      default: ctrl = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/hwrf_chk.sv
// port checker for the hann windowed real fft and its bind
`default_nettype none
module hwrf_chk import hwrf_pkg::*; #(
  parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [BIN_W-1:0] bin_index,
  input wire logic             last_bin
);

  localparam logic [BIN_W-1:0] HALF_IDX = BIN_W'(FRAME_SIZE / 2);

  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_bin |-> bin_index == HALF_IDX)
    else $error("last bin flag on wrong bin");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a bin is pending");

  a_resume: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_bin |=> in_ready)
    else $error("no return to sample collection after last bin");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bin_index))
    else $error("stalled bin request dropped or changed");

endmodule

bind hann_windowed_real_fft_unit hwrf_chk #(.FRAME_SIZE(FRAME_SIZE)) u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .bin_index (out_ch.bin_index),
  .last_bin  (out_ch.last_bin)
);
`default_nettype wire

FILE: dv/hann_windowed_real_fft_unit_tb.sv
// self-checking testbench for the hann windowed real fft unit
`timescale 1ns / 100ps
module hann_windowed_real_fft_unit_tb;
  import hwrf_pkg::*;

  localparam int NPTS  = FRAME_SIZE_DEF;
  localparam int NBINS = NPTS / 2 + 1;
  localparam longint ONE_Q30 = 64'sd1 <<< 30;
  localparam longint QUARTER_RAD = 64'sd1686629713;
  localparam longint SUM_MAX = (64'sd1 <<< 22) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< 22);

  typedef enum int {FK_NOISE, FK_TONE, FK_POS_RAIL, FK_NEG_RAIL, FK_SMALL} frame_kind_t;

  typedef struct {
    logic signed [IN_W-1:0] value;
    bit                     hold_for_drain;
  } sample_req_t;

  typedef struct {
    logic [BIN_W-1:0]        k;
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    last;
  } bin_t;

  logic clk;
  logic rst;
  hwrf_smp_if in_if();
  hwrf_bin_if out_if();

  hann_windowed_real_fft_unit uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  sample_req_t pending_samples[$];
  bin_t        expected_bins[$];
  int          errors = 0;
  int          accepted_cnt = 0;

  // frame state of the spectrum predictor
  longint frame_buf[NPTS];
  int     frame_fill = 0;
  longint hann_q15[NPTS];
  longint cos_q15[NPTS];
  longint nsin_q15[NPTS];

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic longint rnd_half(input longint v, input int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // taylor cosine over the first quadrant, q2.30
  function automatic longint cos_first_quad(input longint x);
    longint xsq, acc, prod;
    xsq = (x * x) >>> 30;
    acc = ONE_Q30;
    for (int j = 6; j >= 1; j--) begin
      prod = (xsq * acc) >>> 30;
      acc  = ONE_Q30 - prod / (longint'(2 * j) * longint'(2 * j - 1));
      if (acc < 0) acc = 0;
    end
    return acc;
  endfunction

  function automatic longint turn_cos(input logic [31:0] ph);
    longint frac, folded, c;
    frac   = longint'(ph[29:0]);
    folded = ph[30] ? (ONE_Q30 - frac) : frac;
    c      = cos_first_quad((folded * QUARTER_RAD) >>> 30);
    return (ph[31:30] == 2'd1 || ph[31:30] == 2'd2) ? -c : c;
  endfunction

  function automatic logic [31:0] turn_frac(input longint m, input longint d);
    longint v;
    v = ((m <<< 32) + d / 2) / d;
    return v[31:0];
  endfunction

  function automatic longint clip_q15(input longint v);
    longint r;
    r = rnd_half(v, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic longint clip_sum(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  task automatic build_coef_tables();
    longint w;
    logic [31:0] ph;
    for (int n = 0; n < NPTS; n++) begin
      w = rnd_half((ONE_Q30 - turn_cos(turn_frac(n, NPTS - 1))) / 2, 15);
      hann_q15[n] = (w > 32767) ? 32767 : w;
      ph = turn_frac(n, NPTS);
      cos_q15[n]  = clip_q15(turn_cos(ph));
      nsin_q15[n] = clip_q15(-turn_cos(ph - 32'h4000_0000));
    end
  endtask

  // collect one sample; a full frame yields its spectrum bins
  task automatic take_sample(input logic signed [IN_W-1:0] s);
    longint xw[NPTS];
    longint re, im;
    bin_t b;
    frame_buf[frame_fill] = longint'(s);
    frame_fill++;
    if (frame_fill < NPTS) return;
    frame_fill = 0;
    for (int n = 0; n < NPTS; n++) xw[n] = rnd_half(frame_buf[n] * hann_q15[n], 15);
    for (int k = 0; k < NBINS; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < NPTS; n++) begin
        re += rnd_half(xw[n] * cos_q15[(n * k) % NPTS], 15);
        im += rnd_half(xw[n] * nsin_q15[(n * k) % NPTS], 15);
      end
      b.k    = BIN_W'(k);
      b.re   = OUT_W'(clip_sum(re));
      b.im   = OUT_W'(clip_sum(im));
      b.last = (k == NPTS / 2);
      expected_bins.push_back(b);
    end
  endtask

  task automatic queue_sample(input logic signed [IN_W-1:0] v, input bit hold);
    sample_req_t r;
    r.value = v;
    r.hold_for_drain = hold;
    pending_samples.push_back(r);
  endtask

  task automatic queue_frame(input frame_kind_t kind, input bit hold);
    real amp, freq, phs;
    logic signed [IN_W-1:0] v;
    amp  = $urandom_range(1000, 32767);
    freq = $urandom_range(0, NPTS / 2);
    phs  = $urandom_range(0, 628) / 100.0;
    for (int n = 0; n < NPTS; n++) begin
      case (kind)
        FK_NOISE:    v = IN_W'($urandom);
        FK_TONE:     v = IN_W'($rtoi(amp * $cos(6.2831853 * freq * n / NPTS + phs)));
        FK_POS_RAIL: v = 16'sh7fff;
        FK_NEG_RAIL: v = -16'sh8000;
        default:     v = IN_W'($urandom_range(0, 15)) - 16'sd8;
      endcase
      queue_sample(v, hold && n == 0);
    end
  endtask

  // sender: bursts with random gaps, requests change on the falling edge
  int sent_seen = 0;
  int burst_left = 8;
  int gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_if.valid  <= 1'b0;
      in_if.sample <= '0;
    end else begin
      if (accepted_cnt != sent_seen) begin
        sent_seen = accepted_cnt;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
      if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0 &&
                   (!pending_samples[0].hold_for_drain || expected_bins.size() == 0)) begin
        in_if.valid  <= 1'b1;
        in_if.sample <= pending_samples[0].value;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && in_if.valid && in_if.ready) begin
      take_sample(in_if.sample);
      void'(pending_samples.pop_front());
      accepted_cnt++;
    end
  end

  // receiver: stall style is redrawn at random among four styles
  int rx_cycle = 0;
  int rx_mode = 0;

  always @(negedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 2) != 0);
        2:       out_if.ready <= (rx_cycle % 7 >= 3);
        default: out_if.ready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    bin_t exp_b;
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_bins.size() == 0) begin
        $display("%0t: unexpected bin k=%0d re=%0d im=%0d last=%0b", $time,
                 out_if.bin_index, out_if.real_part, out_if.imag_part, out_if.last_bin);
        errors++;
      end else begin
        exp_b = expected_bins.pop_front();
        if (out_if.bin_index !== exp_b.k || out_if.real_part !== exp_b.re ||
            out_if.imag_part !== exp_b.im || out_if.last_bin !== exp_b.last) begin
          $display("%0t: bin mismatch expected k=%0d re=%0d im=%0d last=%0b", $time,
                   exp_b.k, exp_b.re, exp_b.im, exp_b.last);
          $display("%0t:              actual k=%0d re=%0d im=%0d last=%0b", $time,
                   out_if.bin_index, out_if.real_part, out_if.imag_part, out_if.last_bin);
          errors++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic signed [IN_W-1:0] edge_vals[25];
    rst = 1'b1;
    in_if.valid  = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    build_coef_tables();
    edge_vals = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001,
                  16'sh5555, -16'sh5556, 16'sh4000, -16'sh4000, 16'sh7ffe,
                  -16'sh7fff, 16'sh00ff, -16'sh0100, 16'sh7fff, 16'sh7fff,
                  -16'sh8000, -16'sh8000, 16'sh0f0f, 16'sh3333, -16'sh3334,
                  16'sh0002, 16'sh1000, -16'sh1001, 16'sh7fff, -16'sh8000};
    foreach (edge_vals[i]) queue_sample(edge_vals[i], 1'b0);
    // random tail completes the first frame
    for (int i = 25; i < NPTS; i++) queue_sample(IN_W'($urandom), 1'b0);
    queue_frame(FK_POS_RAIL, 1'b0);
    queue_frame(FK_TONE, 1'b1);
    queue_frame(FK_NEG_RAIL, 1'b0);
    queue_frame(FK_NOISE, 1'b0);
    queue_frame(frame_kind_t'($urandom_range(0, 4)), 1'b0);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pending_samples.size() > 0 || expected_bins.size() > 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
